FILE: rtl/core/pcbb_pkg.sv
package pcbb_pkg;

	localparam int RCNT_W  = 6;   // restart count, up to 63
	localparam int STEP_W  = 7;   // result index within one command, up to 64 results
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [1:0] FN_KEY    = 2'd0;
	localparam logic [1:0] FN_VALUE  = 2'd1;
	localparam logic [1:0] FN_END    = 2'd2;
	localparam logic [1:0] FN_FINISH = 2'd3;

	localparam logic [2:0] CNT_BYTE = 3'd1;
	localparam logic [2:0] CNT_WORD = 3'd4;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_BYTE,
		CMD_HDR,
		CMD_HDR_BYTE,
		CMD_FINISH
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic [8:0]  key_length;
		logic [31:0] value_length;
	} item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  out_byte_count;
		logic        last_of_run;
		logic        restart_overflow;
	} result_t;

	// one classified request, handed from the front to the back
	typedef struct packed {
		cmd_op_t           op;
		logic              rec_en;
		logic [RCNT_W-1:0] rec_idx;
		logic [31:0]       rec_val;
		logic [31:0]       shared;
		logic [31:0]       suffix_len;
		logic [31:0]       value_length;
		logic [7:0]        data;
		logic [RCNT_W-1:0] fin_count;
		logic              ovf;
	} cmd_t;

endpackage

FILE: rtl/core/pcbb_front.sv
module pcbb_front import pcbb_pkg::*; #(
	parameter int MAX_KEY_BYTES = 256,
	parameter int MAX_RESTARTS  = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	input  logic        q_full,
	output logic        push,
	output cmd_t        cmd
);

	localparam int KPW = $clog2(MAX_KEY_BYTES + 1);
	localparam int AW  = $clog2(MAX_KEY_BYTES);
	localparam int CW  = (KPW > 9) ? KPW : 9;
	localparam logic [KPW-1:0]    KP_MAX   = KPW'(MAX_KEY_BYTES);
	localparam logic [RCNT_W-1:0] RCNT_MAX = RCNT_W'(MAX_RESTARTS);

	logic [7:0]        interval_q;
	logic [KPW-1:0]    kp_q, kp_n, kp_d;
	logic [KPW-1:0]    plen_q, plen_n;
	logic              hdr_q, hdr_n;
	logic              rst_q, rst_n, rst_e;
	logic [7:0]        esr_q, esr_n, esr_e;
	logic [31:0]       boff_q, boff_n;
	logic [RCNT_W-1:0] rcnt_q, rcnt_n, rcnt_e;
	logic              ovf_q, ovf_n, ovf_e;

	logic [7:0]        key_mem [MAX_KEY_BYTES];
	logic [7:0]        key_rd_q;
	logic              key_we;
	logic              key_out;

	logic              accept;
	logic              start;
	logic              match;
	logic [CW-1:0]     plen_c, kl_c, min_c, kp_c, kp1_c;
	logic [31:0]       shared32;
	cmd_op_t           op;
	logic              rec_en;

	assign accept     = item_valid && !q_full;
	assign item_stall = q_full;

	always_comb begin
		start  = !hdr_q && (kp_q == '0) && (item.func != FN_FINISH);
		rst_e  = rst_q;
		esr_e  = esr_q;
		rcnt_e = rcnt_q;
		ovf_e  = ovf_q;
		rec_en = 1'b0;
		if (start) begin
			if (esr_q >= interval_q) begin
				rst_e = 1'b1;
				esr_e = '0;
				if (rcnt_q < RCNT_MAX) begin
					rec_en = 1'b1;
					rcnt_e = rcnt_q + RCNT_W'(1);
				end else begin
					ovf_e = 1'b1;
				end
			end else begin
				rst_e = 1'b0;
			end
		end

		plen_c = CW'(plen_q);
		kl_c   = CW'(item.key_length);
		kp_c   = CW'(kp_q);
		kp1_c  = kp_c + CW'(1);
		if (rst_e) begin
			min_c = '0;
		end else begin
			min_c = (plen_c < kl_c) ? plen_c : kl_c;
		end
		match = (kp_c < min_c) && (kp_q < KP_MAX) && (key_rd_q == item.data_byte);

		op       = CMD_NONE;
		shared32 = 32'(kp_q);
		key_out  = 1'b0;
		kp_n     = kp_q;
		plen_n   = plen_q;
		hdr_n    = hdr_q;
		rst_n    = rst_e;
		esr_n    = esr_e;
		boff_n   = boff_q;
		rcnt_n   = rcnt_e;
		ovf_n    = ovf_e;

		case (item.func)
			FN_KEY: begin
				if (!hdr_q) begin
					if (match) begin
						kp_n = kp_q + KPW'(1);
						if (kp1_c == min_c) begin
							op       = CMD_HDR;
							shared32 = 32'(kp_q) + 32'd1;
							boff_n   = boff_q + 32'd12;
							hdr_n    = 1'b1;
						end
					end else begin
						op      = CMD_HDR_BYTE;
						boff_n  = boff_q + 32'd13;
						hdr_n   = 1'b1;
						key_out = 1'b1;
					end
				end else begin
					op      = CMD_BYTE;
					boff_n  = boff_q + 32'd1;
					key_out = 1'b1;
				end
			end
			FN_VALUE: begin
				if (!hdr_q) begin
					op     = CMD_HDR_BYTE;
					boff_n = boff_q + 32'd13;
				end else begin
					op     = CMD_BYTE;
					boff_n = boff_q + 32'd1;
				end
				hdr_n = 1'b1;
			end
			FN_END: begin
				if (!hdr_q) begin
					op     = CMD_HDR;
					boff_n = boff_q + 32'd12;
				end
				plen_n = kp_q;
				esr_n  = (esr_e != 8'hFF) ? esr_e + 8'd1 : esr_e;
				hdr_n  = 1'b0;
				kp_n   = '0;
				rst_n  = 1'b0;
			end
			FN_FINISH: begin
				op     = CMD_FINISH;
				kp_n   = '0;
				plen_n = '0;
				hdr_n  = 1'b0;
				rst_n  = 1'b0;
				esr_n  = '0;
				boff_n = '0;
				rcnt_n = RCNT_W'(1);
				ovf_n  = 1'b0;
			end
			default: ;
		endcase

		// bytes past the key store are sent but not kept
		key_we = 1'b0;
		if (key_out && (kp_q < KP_MAX)) begin
			key_we = accept;
			kp_n   = kp_q + KPW'(1);
		end

		kp_d = accept ? kp_n : kp_q;
		push = accept && ((op != CMD_NONE) || rec_en);
	end

	always_comb begin
		cmd.op           = op;
		cmd.rec_en       = rec_en;
		cmd.rec_idx      = rcnt_q;
		cmd.rec_val      = boff_q;
		cmd.shared       = shared32;
		cmd.suffix_len   = 32'(item.key_length) - shared32;
		cmd.value_length = item.value_length;
		cmd.data         = item.data_byte;
		cmd.fin_count    = rcnt_q;
		cmd.ovf          = (item.func == FN_FINISH) ? ovf_q : ovf_e;
	end

	// read port runs one key position ahead so the compare byte is ready
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[kp_q[AW-1:0]] <= item.data_byte;
		end
		if (kp_d < KP_MAX) begin
			key_rd_q <= key_mem[kp_d[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 8'd16;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			plen_q <= '0;
			hdr_q  <= 1'b0;
			rst_q  <= 1'b0;
			esr_q  <= '0;
			boff_q <= '0;
			rcnt_q <= RCNT_W'(1);
			ovf_q  <= 1'b0;
		end else if (accept) begin
			kp_q   <= kp_n;
			plen_q <= plen_n;
			hdr_q  <= hdr_n;
			rst_q  <= rst_n;
			esr_q  <= esr_n;
			boff_q <= boff_n;
			rcnt_q <= rcnt_n;
			ovf_q  <= ovf_n;
		end
	end

endmodule

FILE: rtl/core/pcbb_queue.sv
module pcbb_queue import pcbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full       = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (Q_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/pcbb_back.sv
module pcbb_back import pcbb_pkg::*; #(
	parameter int MAX_RESTARTS = 63
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  cmd_t    head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int RIW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;

	logic [31:0]       rst_mem [MAX_RESTARTS];
	logic [31:0]       rd_q;
	logic [STEP_W-1:0] step_q, step_d, last_step;
	logic              out_valid_q;
	result_t           out_q, res_d;
	logic              slot_free, emit;

	assign slot_free = !out_valid_q || !result_stall;
	assign emit      = head_valid && (head.op != CMD_NONE) && slot_free;

	always_comb begin
		case (head.op)
			CMD_BYTE:     last_step = STEP_W'(0);
			CMD_HDR:      last_step = STEP_W'(2);
			CMD_HDR_BYTE: last_step = STEP_W'(3);
			CMD_FINISH:   last_step = STEP_W'(head.fin_count);
			default:      last_step = STEP_W'(0);
		endcase
		pop = head_valid && ((head.op == CMD_NONE) || (emit && (step_q == last_step)));
		if (pop) begin
			step_d = '0;
		end else if (emit) begin
			step_d = step_q + STEP_W'(1);
		end else begin
			step_d = step_q;
		end
	end

	always_comb begin
		res_d.out_word         = '0;
		res_d.out_byte_count   = CNT_WORD;
		res_d.last_of_run      = (step_q == last_step);
		res_d.restart_overflow = head.ovf;
		case (head.op)
			CMD_BYTE: begin
				res_d.out_word       = 32'(head.data);
				res_d.out_byte_count = CNT_BYTE;
			end
			CMD_HDR, CMD_HDR_BYTE: begin
				if (step_q == STEP_W'(0)) begin
					res_d.out_word = head.shared;
				end else if (step_q == STEP_W'(1)) begin
					res_d.out_word = head.suffix_len;
				end else if (step_q == STEP_W'(2)) begin
					res_d.out_word = head.value_length;
				end else begin
					res_d.out_word       = 32'(head.data);
					res_d.out_byte_count = CNT_BYTE;
				end
			end
			CMD_FINISH: begin
				// restart point zero is always offset zero and is never stored
				if (step_q < STEP_W'(head.fin_count)) begin
					res_d.out_word = (step_q == '0) ? 32'd0 : rd_q;
				end else begin
					res_d.out_word = 32'(head.fin_count);
				end
			end
			default: ;
		endcase
	end

	// read address follows the next step, so rd_q matches step_q for every step below MAX_RESTARTS
	always_ff @(posedge clk) begin
		if (pop && head.rec_en) begin
			rst_mem[head.rec_idx[RIW-1:0]] <= head.rec_val;
		end
		if (step_d < STEP_W'(MAX_RESTARTS)) begin
			rd_q <= rst_mem[step_d[RIW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: rtl/core/prefix_compressed_block_builder_unit.sv
// Prefix-compressed block builder. Key bytes, value bytes, end-of-entry and finish
// requests come in on the item channel; results leave on the result channel, with
// headers as three 32-bit words and data as single bytes. The front takes one
// request per cycle while the four-entry command queue has room. The back emits
// one result per cycle unless stalled: a byte request one, a header request three
// or four, and finish restart_count + 1, the restart offsets and then the count.
// A matching key byte that does not end the shared prefix and an end of entry
// after the header produce nothing and never reach the back. No clearing pass
// follows reset or finish. restart_interval is written through cfg_we/cfg_wdata;
// the user must do so only while idle; the block does not enforce it.
module prefix_compressed_block_builder_unit import pcbb_pkg::*; #(
	parameter int MAX_KEY_BYTES = 256,
	parameter int MAX_RESTARTS  = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	logic push, q_full, pop, head_valid;
	cmd_t push_cmd, head;

	pcbb_front #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES),
		.MAX_RESTARTS  (MAX_RESTARTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	pcbb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	pcbb_back #(
		.MAX_RESTARTS (MAX_RESTARTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
